// ----- rtl/srcg_pkg.sv -----
// ----------------------------------------------------------------------------
// srcg_pkg
// Shared widths, codes and controller/datapath types for the smallest range
// covering groups core.
// ----------------------------------------------------------------------------
package srcg_pkg;

	localparam int GC_W     = 5;
	localparam int GRP_W    = 4;
	localparam int SAMPLE_W = 32;
	localparam int SPREAD_W = 32;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic [GC_W-1:0]    GC_RESET      = 5'd2;
	localparam logic [PADDR_W-1:0] REG_GROUP_CNT = 2'd0;

	localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNSEEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_KEY_RD,
		CMD_KEY_LATCH,
		CMD_CMP,
		CMD_PUT,
		CMD_SCAN_INIT,
		CMD_SCAN_RD,
		CMD_SCAN_UPD,
		CMD_SPAN,
		CMD_BEST,
		CMD_FLUSH
	} cmd_t;

	typedef struct packed {
		logic i_done;
		logic j_one;
		logic key_before;
		logic all_seen;
		logic g_last;
		logic err_next;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/smallest_range_covering_groups_core.sv -----
// ----------------------------------------------------------------------------
// smallest_range_covering_groups_core
// Collects (group, sample) items, sorts them after the last one and reports
// the smallest spread that covers every group.
//
// channel   handshake              payload
// config    psel/penable/pwrite    paddr, pwdata, prdata (group_count)
// input     in_valid/in_ready      group, sample, final_req
// output    out_valid/out_ready    best_spread, status
//
// Loading accepts one item per cycle. After the last item, the insertion sort
// in the item memory latches each key and shifts larger entries up until it
// fits; the scan reads each item and, once all groups are covered, takes the
// span of their latest samples, then hands over the result. The item memory
// has one write port, setting the sort pace. Reset clears control state at once.
// A result held by a stalled output does not block loading of the next set.
// ----------------------------------------------------------------------------
module smallest_range_covering_groups_core #(
	parameter int MAX_GROUPS = 16,
	parameter int MAX_ITEMS  = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [srcg_pkg::PADDR_W-1:0]          paddr,
	input  logic [srcg_pkg::PDATA_W-1:0]          pwdata,
	output logic [srcg_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [srcg_pkg::GRP_W-1:0]            group,
	input  logic signed [srcg_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  final_req,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [srcg_pkg::SPREAD_W-1:0]         best_spread,
	output logic [srcg_pkg::STATUS_W-1:0]         status
);

	localparam int NW = $clog2(MAX_GROUPS + 1);

	logic [srcg_pkg::GC_W-1:0] gc_q;
	logic [NW-1:0]             n_eff;
	srcg_pkg::cmd_t            cmd;
	srcg_pkg::stat_t           st;

	assign pready = 1'b1;
	assign prdata = (paddr == srcg_pkg::REG_GROUP_CNT) ?
		srcg_pkg::PDATA_W'(gc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q <= srcg_pkg::GC_RESET;
		end else if (psel && penable && pwrite && (paddr == srcg_pkg::REG_GROUP_CNT)) begin
			gc_q <= pwdata[srcg_pkg::GC_W-1:0];
		end
	end

	always_comb begin
		if (gc_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(gc_q) > MAX_GROUPS) begin
			n_eff = NW'(MAX_GROUPS);
		end else begin
			n_eff = NW'(gc_q);
		end
	end

	srcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.final_req (final_req),
		.st        (st),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	srcg_dp #(
		.MAX_GROUPS (MAX_GROUPS),
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS),
		.NW         (NW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.n_groups    (n_eff),
		.group       (group),
		.sample      (sample),
		.out_ready   (out_ready),
		.st          (st),
		.out_valid   (out_valid),
		.best_spread (best_spread),
		.status      (status)
	);

endmodule

// ----- rtl/srcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// srcg_ctrl
// Sequencer for load, insertion sort, coverage scan and result hand-off.
// ----------------------------------------------------------------------------
module srcg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            final_req,
	input  srcg_pkg::stat_t st,
	output logic            in_ready,
	output srcg_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_KEY,
		S_KEYW,
		S_CMP,
		S_PUT,
		S_SCAN_RD,
		S_SCAN_UPD,
		S_SPAN,
		S_BEST,
		S_DONE
	} state_t;

	state_t state_q, state_nxt;
	logic   fire;

	assign in_ready = (state_q == S_LOAD);
	assign fire     = in_valid && in_ready;

	always_comb begin
		cmd       = srcg_pkg::CMD_NONE;
		state_nxt = state_q;
		case (state_q)
			S_LOAD: begin
				if (fire) begin
					cmd = srcg_pkg::CMD_LOAD;
					if (final_req) begin
						state_nxt = st.err_next ? S_DONE : S_KEY;
					end
				end
			end
			S_KEY: begin
				if (st.i_done) begin
					cmd       = srcg_pkg::CMD_SCAN_INIT;
					state_nxt = S_SCAN_RD;
				end else begin
					cmd       = srcg_pkg::CMD_KEY_RD;
					state_nxt = S_KEYW;
				end
			end
			S_KEYW: begin
				cmd       = srcg_pkg::CMD_KEY_LATCH;
				state_nxt = S_CMP;
			end
			S_CMP: begin
				if (st.key_before) begin
					cmd       = srcg_pkg::CMD_CMP;
					state_nxt = st.j_one ? S_PUT : S_CMP;
				end else begin
					cmd       = srcg_pkg::CMD_PUT;
					state_nxt = S_KEY;
				end
			end
			S_PUT: begin
				cmd       = srcg_pkg::CMD_PUT;
				state_nxt = S_KEY;
			end
			S_SCAN_RD: begin
				if (st.i_done) begin
					state_nxt = S_DONE;
				end else begin
					cmd       = srcg_pkg::CMD_SCAN_RD;
					state_nxt = S_SCAN_UPD;
				end
			end
			S_SCAN_UPD: begin
				cmd       = srcg_pkg::CMD_SCAN_UPD;
				state_nxt = st.all_seen ? S_SPAN : S_SCAN_RD;
			end
			S_SPAN: begin
				cmd       = srcg_pkg::CMD_SPAN;
				state_nxt = st.g_last ? S_BEST : S_SPAN;
			end
			S_BEST: begin
				cmd       = srcg_pkg::CMD_BEST;
				state_nxt = S_SCAN_RD;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd       = srcg_pkg::CMD_FLUSH;
					state_nxt = S_LOAD;
				end
			end
			default: begin
				state_nxt = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/srcg_dp.sv -----
// ----------------------------------------------------------------------------
// srcg_dp
// Item memory, sort registers, per-group latest samples, span search and
// result register.
// ----------------------------------------------------------------------------
module srcg_dp #(
	parameter int MAX_GROUPS = 16,
	parameter int MAX_ITEMS  = 256,
	parameter int VALUE_BITS = 32,
	parameter int NW         = $clog2(MAX_GROUPS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srcg_pkg::cmd_t                      cmd,
	input  logic [NW-1:0]                       n_groups,
	input  logic [srcg_pkg::GRP_W-1:0]          group,
	input  logic signed [srcg_pkg::SAMPLE_W-1:0] sample,
	input  logic                                out_ready,
	output srcg_pkg::stat_t                     st,
	output logic                                out_valid,
	output logic [srcg_pkg::SPREAD_W-1:0]       best_spread,
	output logic [srcg_pkg::STATUS_W-1:0]       status
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

	typedef struct packed {
		logic [VALUE_BITS-1:0] val;
		logic [GW-1:0]         grp;
	} ent_t;

	ent_t mem_q [MAX_ITEMS];
	ent_t rd_q, key_q, wr_data;
	logic            wr_en, rd_en;
	logic [AW-1:0]   wr_addr, rd_addr;

	logic [CW-1:0]   cnt_q, i_q, j_q;
	logic            err_q, best_vld_q, out_valid_q;
	logic [MAX_GROUPS-1:0] seen_q, seen_nxt, all_mask, sel_mask;
	logic [VALUE_BITS-1:0] latest_q [MAX_GROUPS];
	logic [GW-1:0]   g_q;
	logic [VALUE_BITS-1:0] lo_q, hi_q, best_q, lat_g, spread_w;
	logic [srcg_pkg::SPREAD_W-1:0] spread_out_q;
	logic [srcg_pkg::STATUS_W-1:0] status_out_q;

	logic            grp_bad, full, store_ok, better;
	logic [VALUE_BITS-1:0] in_val;
	logic [srcg_pkg::STATUS_W-1:0] st_code;

	assign in_val   = sample[VALUE_BITS-1:0];
	assign grp_bad  = (32'(group) >= 32'(n_groups));
	assign full     = (cnt_q == CW'(MAX_ITEMS));
	assign store_ok = !grp_bad && !full;

	always_comb begin
		for (int k = 0; k < MAX_GROUPS; k++) begin
			all_mask[k] = (k < 32'(n_groups));
			sel_mask[k] = (32'(rd_q.grp) == k);
		end
	end
	assign seen_nxt = seen_q | sel_mask;
	assign lat_g    = latest_q[g_q];
	assign spread_w = hi_q - lo_q;
	assign better   = !best_vld_q || (spread_w < best_q);

	assign st.i_done     = (i_q >= cnt_q);
	assign st.j_one      = (j_q == CW'(1));
	assign st.key_before = ($signed(key_q.val) < $signed(rd_q.val)) ||
		((key_q.val == rd_q.val) && (key_q.grp < rd_q.grp));
	assign st.all_seen   = ((seen_nxt & all_mask) == all_mask);
	assign st.g_last     = ((32'(g_q) + 32'd1) == 32'(n_groups));
	assign st.err_next   = err_q || grp_bad || full;
	assign st.out_free   = !out_valid_q || out_ready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = key_q;
		rd_en   = 1'b0;
		rd_addr = i_q[AW-1:0];
		case (cmd)
			srcg_pkg::CMD_LOAD: begin
				wr_en        = store_ok;
				wr_data.val  = in_val;
				wr_data.grp  = GW'(group);
			end
			srcg_pkg::CMD_KEY_RD: begin
				rd_en = 1'b1;
			end
			srcg_pkg::CMD_KEY_LATCH: begin
				rd_en   = 1'b1;
				rd_addr = AW'(j_q - CW'(1));
			end
			srcg_pkg::CMD_CMP: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = rd_q;
				rd_en   = (j_q >= CW'(2));
				rd_addr = AW'(j_q - CW'(2));
			end
			srcg_pkg::CMD_PUT: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
			end
			srcg_pkg::CMD_SCAN_RD: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_comb begin
		if (err_q) begin
			st_code = srcg_pkg::ST_ERROR;
		end else if (best_vld_q) begin
			st_code = srcg_pkg::ST_FOUND;
		end else begin
			st_code = srcg_pkg::ST_UNSEEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			err_q       <= 1'b0;
			seen_q      <= '0;
			best_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				srcg_pkg::CMD_LOAD: begin
					if (store_ok) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						err_q <= 1'b1;
					end
				end
				srcg_pkg::CMD_SCAN_UPD: begin
					seen_q <= seen_nxt;
				end
				srcg_pkg::CMD_BEST: begin
					if (better) begin
						best_vld_q <= 1'b1;
					end
				end
				srcg_pkg::CMD_FLUSH: begin
					out_valid_q <= 1'b1;
					cnt_q       <= '0;
					err_q       <= 1'b0;
					seen_q      <= '0;
					best_vld_q  <= 1'b0;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			srcg_pkg::CMD_LOAD: begin
				i_q <= CW'(1);
			end
			srcg_pkg::CMD_KEY_RD: begin
				j_q <= i_q;
			end
			srcg_pkg::CMD_KEY_LATCH: begin
				key_q <= rd_q;
			end
			srcg_pkg::CMD_CMP: begin
				j_q <= j_q - CW'(1);
			end
			srcg_pkg::CMD_PUT: begin
				i_q <= i_q + CW'(1);
			end
			srcg_pkg::CMD_SCAN_INIT: begin
				i_q <= '0;
			end
			srcg_pkg::CMD_SCAN_RD: begin
				i_q <= i_q + CW'(1);
			end
			srcg_pkg::CMD_SCAN_UPD: begin
				latest_q[rd_q.grp] <= rd_q.val;
				g_q                <= '0;
			end
			srcg_pkg::CMD_SPAN: begin
				if (g_q == '0) begin
					lo_q <= lat_g;
					hi_q <= lat_g;
				end else begin
					if ($signed(lat_g) < $signed(lo_q)) begin
						lo_q <= lat_g;
					end
					if ($signed(lat_g) > $signed(hi_q)) begin
						hi_q <= lat_g;
					end
				end
				g_q <= g_q + GW'(1);
			end
			srcg_pkg::CMD_BEST: begin
				if (better) begin
					best_q <= spread_w;
				end
			end
			srcg_pkg::CMD_FLUSH: begin
				status_out_q <= st_code;
				spread_out_q <= (st_code == srcg_pkg::ST_FOUND) ?
					srcg_pkg::SPREAD_W'(best_q) : '0;
			end
			default: begin
				g_q <= g_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign best_spread = spread_out_q;
	assign status      = status_out_q;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives (group, sample) beats into the smallest range covering groups core,
// predicts each data set's best spread and status, and checks every result.
// Configuration is rewritten between data sets while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import srcg_pkg::*;

	localparam int NGRP      = 16;
	localparam int NSTORE    = 256;
	localparam int N_RANDOM  = 880;
	localparam int CYC_LIMIT = 3000000;

	typedef struct {
		logic [GRP_W-1:0]    grp;
		logic [SAMPLE_W-1:0] smp;
		logic                fin;
		logic                chk;
		logic [SPREAD_W-1:0] spread;
		logic [STATUS_W-1:0] st;
	} row_t;

	typedef struct {
		logic [SPREAD_W-1:0] spread;
		logic [STATUS_W-1:0] st;
		logic                chk;
		logic [SPREAD_W-1:0] dspread;
		logic [STATUS_W-1:0] dst;
	} res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 in_valid = 1'b0, in_ready;
	logic [GRP_W-1:0]     group = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                 final_req = 1'b0;
	logic                 out_valid, out_ready = 1'b0;
	logic [SPREAD_W-1:0]  best_spread;
	logic [STATUS_W-1:0]  status;

	smallest_range_covering_groups_core dut (.*);

	initial forever #4 clk = ~clk;

	// predictor state
	logic [GC_W-1:0]           gc_reg;
	logic signed [SAMPLE_W-1:0] set_smp[$];
	logic [GRP_W-1:0]          set_grp[$];
	logic                      set_err;
	res_t                      spread_q[$];
	int                        n_err, cyc, n_sets;

	function automatic int active_groups();
		if (gc_reg == 0) return 1;
		if (gc_reg > NGRP) return NGRP;
		return gc_reg;
	endfunction

	function automatic res_t close_set();
		res_t r;
		int n, idx[$], t;
		logic signed [SAMPLE_W-1:0] last_smp[NGRP];
		logic [NGRP-1:0] seen, all;
		logic signed [63:0] lo, hi;
		logic [63:0] best, spr;
		logic have;
		n = active_groups();
		r.spread = '0;
		r.chk = 1'b0;
		if (set_err) begin
			r.st = ST_ERROR;
			return r;
		end
		foreach (set_smp[i]) idx = {idx, i};
		for (int i = 1; i < idx.size(); i++) begin
			t = idx[i];
			for (int j = i; j > 0; j--) begin
				if (set_smp[t] < set_smp[idx[j-1]] ||
				    (set_smp[t] == set_smp[idx[j-1]] && set_grp[t] < set_grp[idx[j-1]])) begin
					idx[j] = idx[j-1];
					idx[j-1] = t;
				end else break;
			end
		end
		seen = '0;
		all = (n >= NGRP) ? '1 : ((NGRP'(1) << n) - 1);
		have = 1'b0;
		best = '0;
		foreach (idx[k]) begin
			last_smp[set_grp[idx[k]]] = set_smp[idx[k]];
			seen[set_grp[idx[k]]] = 1'b1;
			if ((seen & all) == all) begin
				lo = last_smp[0];
				hi = lo;
				for (int g = 1; g < n; g++) begin
					if (last_smp[g] < lo) lo = last_smp[g];
					if (last_smp[g] > hi) hi = last_smp[g];
				end
				spr = hi - lo;
				if (!have || spr < best) begin
					best = spr;
					have = 1'b1;
				end
			end
		end
		r.st = have ? ST_FOUND : ST_UNSEEN;
		r.spread = have ? best[31:0] : '0;
		return r;
	endfunction

	task automatic gap(input int lo, input int hi);
		repeat ($urandom_range(hi, lo)) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; paddr = a; pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		if (a == REG_GROUP_CNT) gc_reg = d[GC_W-1:0];
	endtask

	task automatic send(input row_t r);
		res_t x;
		int n;
		gap(0, 5);
		group = r.grp; sample = r.smp; final_req = r.fin; in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		n = active_groups();
		if (r.grp >= n || set_smp.size() >= NSTORE) set_err = 1'b1;
		else begin
			set_smp = {set_smp, r.smp};
			set_grp = {set_grp, r.grp};
		end
		if (r.fin) begin
			x = close_set();
			x.chk = r.chk; x.dspread = r.spread; x.dst = r.st;
			spread_q = {spread_q, x};
			set_smp.delete(); set_grp.delete(); set_err = 1'b0;
			n_sets++;
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (spread_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// result sampling and readiness
	initial begin
		res_t e;
		forever begin
			@(negedge clk);
			out_ready = 1'b0;
			repeat ($urandom_range(5, 0)) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			if (spread_q.size() == 0) begin
				$error("result with nothing expected");
				n_err++;
			end else begin
				e = spread_q.pop_front();
				if (e.chk && (e.dst !== e.st || e.dspread !== e.spread)) begin
					$error("table row disagrees with predictor");
					n_err++;
				end
				if (best_spread !== e.spread) begin
					$error("best_spread exp %0d got %0d", e.spread, best_spread);
					n_err++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					n_err++;
				end
			end
		end
	end

	initial begin
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc > CYC_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	row_t dir_tbl[] = '{
		'{4'd0, 32'd5, 1'b1, 1'b1, 32'd0, ST_UNSEEN},
		'{4'd0, 32'h8000_0000, 1'b0, 1'b0, 32'd0, ST_FOUND},
		'{4'd1, 32'h7fff_ffff, 1'b1, 1'b1, 32'hffff_ffff, ST_FOUND},
		'{4'd2, 32'd1, 1'b1, 1'b1, 32'd0, ST_ERROR},
		'{4'd15, 32'd1, 1'b0, 1'b0, 32'd0, ST_FOUND},
		'{4'd0, 32'd1, 1'b1, 1'b1, 32'd0, ST_UNSEEN},
		'{4'd1, 32'd10, 1'b0, 1'b0, 32'd0, ST_FOUND},
		'{4'd0, 32'd3, 1'b0, 1'b0, 32'd0, ST_FOUND},
		'{4'd1, 32'd4, 1'b0, 1'b0, 32'd0, ST_FOUND},
		'{4'd0, 32'd20, 1'b1, 1'b0, 32'd0, ST_FOUND},
		'{4'd0, 32'd7, 1'b0, 1'b0, 32'd0, ST_FOUND},
		'{4'd1, 32'd7, 1'b1, 1'b1, 32'd0, ST_FOUND}
	};

	task automatic random_set(input int len, input int bad_pct, input logic narrow);
		row_t r;
		int n;
		n = active_groups();
		for (int i = 0; i < len; i++) begin
			r.grp = ($urandom_range(99, 0) < bad_pct) ? GRP_W'($urandom_range(15, 0))
			        : GRP_W'($urandom_range(n - 1, 0));
			r.smp = narrow ? $signed($urandom_range(40, 0)) - 20 : $urandom();
			r.fin = (i == len - 1);
			r.chk = 1'b0;
			send(r);
		end
	endtask

	initial begin
		int sent, g, len;
		n_err = 0; n_sets = 0; set_err = 1'b0; gc_reg = GC_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_tbl[i]) begin
			if (i == 3) begin
				drain();
				cfg_write(REG_GROUP_CNT, 32'd0);
			end
			if (i == 4) begin
				drain();
				cfg_write(REG_GROUP_CNT, 32'd31);
			end
			if (i == 6) begin
				drain();
				cfg_write(REG_GROUP_CNT, 32'd2);
			end
			send(dir_tbl[i]);
		end
		// overflow the store
		drain();
		cfg_write(REG_GROUP_CNT, 32'd1);
		random_set(NSTORE + 1, 0, 1'b1);
		drain();
		sent = 0;
		while (sent < N_RANDOM) begin
			if ($urandom_range(3, 0) == 0) begin
				drain();
				g = $urandom_range(4, 0);
				cfg_write(REG_GROUP_CNT, g == 0 ? 32'd16 : g == 1 ? 32'd1 :
				          32'($urandom_range(31, 0)));
			end
			len = $urandom_range(12, 1);
			random_set(len, ($urandom_range(9, 0) == 0) ? 20 : 0,
			           1'($urandom_range(1, 0)));
			sent += len;
		end
		while (spread_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d data sets, group counts 0..31, overflow and bad groups", n_sets);
		if (n_err == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
